FILE: hdl/sbe_pkg.sv
// Shared types and codes for the stack bytecode executor.
// Holds the request/response word layouts, opcode, segment, fault and register codes.
// No dependencies.
package sbe_pkg;

   // instruction classes carried in req_type
   localparam logic [3:0] OP_ADD   = 4'd0;
   localparam logic [3:0] OP_SUB   = 4'd1;
   localparam logic [3:0] OP_NOT   = 4'd2;
   localparam logic [3:0] OP_EQ    = 4'd3;
   localparam logic [3:0] OP_GT    = 4'd4;
   localparam logic [3:0] OP_LT    = 4'd5;
   localparam logic [3:0] OP_AND   = 4'd6;
   localparam logic [3:0] OP_OR    = 4'd7;
   localparam logic [3:0] OP_CJUMP = 4'd8;
   localparam logic [3:0] OP_JUMP  = 4'd9;
   localparam logic [3:0] OP_STACK = 4'd10;

   // push/pop segments
   localparam logic [1:0] SEG_CONST = 2'd0;
   localparam logic [1:0] SEG_ARG   = 2'd1;
   localparam logic [1:0] SEG_LOCAL = 2'd2;
   localparam logic [1:0] SEG_HOST  = 2'd3;

   // fault codes
   localparam logic [1:0] FLT_NONE  = 2'd0;
   localparam logic [1:0] FLT_UNDER = 2'd1;
   localparam logic [1:0] FLT_OVER  = 2'd2;
   localparam logic [1:0] FLT_INDEX = 2'd3;

   // highest valid output format (hex)
   localparam logic [31:0] FMT_MAX = 32'd2;

   // configuration register indexes
   localparam logic [2:0] CSR_ARG_COUNT   = 3'd0;
   localparam logic [2:0] CSR_LOCAL_COUNT = 3'd1;
   localparam logic [2:0] CSR_ARG_WORD0   = 3'd2;

   localparam int          CSR_IDX_W = 3;
   localparam int          WORD_W    = 32;
   localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
   localparam logic [31:0] ALL_ZERO  = 32'h0000_0000;

   // parameter defaults
   localparam int DEF_STACK_DEPTH = 64;
   localparam int DEF_LOCAL_DEPTH = 256;
   localparam int DEF_ARG_SLOTS   = 4;

   typedef struct packed {
      logic [3:0]         req_type;
      logic               is_pop;
      logic [1:0]         segment;
      logic [31:0]        operand;
      logic signed [31:0] host_value;
   } sbe_req_type;

   typedef struct packed {
      logic        jump_taken;
      logic [31:0] jump_target;
      logic        out_valid;
      logic [31:0] out_word;
      logic [1:0]  out_format;
      logic [1:0]  fault;
   } sbe_rsp_type;

endpackage

FILE: hdl/stack_bytecode_executor_unit.sv
// Path: request register, execute, then response register driving rsp_*.
// Throughput: one instruction per cycle; the execute stage holds only while the
//   response register is full and stalled.
// Reset: synchronous, active high; clears stack level, local valid bits,
//   configuration registers and pipeline valids. No clearing pass is needed.
// Top level of the stack bytecode executor: decode, stack cache and local store.
// Depends on sbe_pkg.
module stack_bytecode_executor_unit #(
   parameter int STACK_DEPTH = sbe_pkg::DEF_STACK_DEPTH,
   parameter int LOCAL_DEPTH = sbe_pkg::DEF_LOCAL_DEPTH,
   parameter int ARG_SLOTS   = sbe_pkg::DEF_ARG_SLOTS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  sbe_pkg::sbe_req_type             req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output sbe_pkg::sbe_rsp_type             rsp_data,
   input  logic                             csr_wr_en,
   input  logic [sbe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sbe_pkg::WORD_W-1:0]       csr_wdata
);
   import sbe_pkg::*;

   // Widths derived from the depths.
   localparam int SA_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int LV_W = $clog2(STACK_DEPTH + 1);
   localparam int LA_W = (LOCAL_DEPTH > 1) ? $clog2(LOCAL_DEPTH) : 1;
   localparam int AI_W = (ARG_SLOTS > 1) ? $clog2(ARG_SLOTS) : 1;
   localparam logic [LV_W-1:0] LV_FULL  = LV_W'(STACK_DEPTH);
   localparam logic [8:0]      LOC_MAX  = 9'(LOCAL_DEPTH);
   localparam logic [2:0]      ARG_MAX  = 3'(ARG_SLOTS);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [2:0]        arg_count_ff;
   logic [8:0]        local_count_ff;
   logic [WORD_W-1:0] arg_word_ff [ARG_SLOTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         arg_count_ff   <= '0;
         local_count_ff <= '0;
         for (int k = 0; k < ARG_SLOTS; k++) begin
            arg_word_ff[k] <= '0;
         end
      end else if (csr_wr_en) begin
         if (csr_index == CSR_ARG_COUNT) begin
            arg_count_ff <= csr_wdata[2:0];
         end
         if (csr_index == CSR_LOCAL_COUNT) begin
            local_count_ff <= csr_wdata[8:0];
         end
         for (int k = 0; k < ARG_SLOTS; k++) begin
            if (csr_index == CSR_ARG_WORD0 + CSR_IDX_W'(k)) begin
               arg_word_ff[k] <= csr_wdata;
            end
         end
      end
   end

   // Clamp the counts to what is actually built.
   logic [2:0] eff_args;
   logic [8:0] eff_locals;
   assign eff_args   = (arg_count_ff > ARG_MAX) ? ARG_MAX : arg_count_ff;
   assign eff_locals = (local_count_ff > LOC_MAX) ? LOC_MAX : local_count_ff;

   // ---------------------------------------------------------------------
   // Pipeline control: request register -> execute -> response register
   // ---------------------------------------------------------------------
   logic        ex_vld_ff;
   sbe_req_type ex_req_ff;
   logic        rsp_valid_ff;
   sbe_rsp_type rsp_data_ff;
   logic        exec_go;
   logic        accept;
   // top of stack; also the value a pop-to-local stores
   logic [WORD_W-1:0] tos_ff, tos_in;

   // Execute whenever the response register is empty or being drained.
   assign exec_go   = ex_vld_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = ex_vld_ff && !exec_go;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_vld_ff <= 1'b0;
      end else if (accept) begin
         ex_vld_ff <= 1'b1;
      end else if (exec_go) begin
         ex_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ex_req_ff <= req_data;
      end
   end

   // ---------------------------------------------------------------------
   // Local store: read issued at accept, written by pop-to-local at execute.
   // Valid bits stand in for the all-zero reset contents.
   // ---------------------------------------------------------------------
   logic [WORD_W-1:0]   loc_mem [LOCAL_DEPTH];
   logic [LOCAL_DEPTH-1:0] loc_vld_ff;
   logic [WORD_W-1:0]   loc_rd_ff;
   logic                loc_rvld_ff;
   logic                loc_byp_ff;
   logic [WORD_W-1:0]   loc_bypd_ff;
   logic                loc_we;
   logic [LA_W-1:0]     loc_wa;
   logic [LA_W-1:0]     loc_ra;
   logic [WORD_W-1:0]   loc_val;

   assign loc_ra = req_data.operand[LA_W-1:0];
   assign loc_wa = ex_req_ff.operand[LA_W-1:0];

   always_ff @(posedge clock) begin
      if (loc_we) begin
         loc_mem[loc_wa] <= tos_ff;
      end
      if (accept) begin
         loc_rd_ff <= loc_mem[loc_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loc_vld_ff <= '0;
      end else if (loc_we) begin
         loc_vld_ff[loc_wa] <= 1'b1;
      end
   end

   // Hold a write that lands on the address being read in the same cycle.
   always_ff @(posedge clock) begin
      if (accept) begin
         loc_rvld_ff <= loc_vld_ff[loc_ra];
         loc_byp_ff  <= loc_we && (loc_wa == loc_ra);
         loc_bypd_ff <= tos_ff;
      end
   end

   assign loc_val = loc_byp_ff ? loc_bypd_ff : (loc_rvld_ff ? loc_rd_ff : ALL_ZERO);

   // ---------------------------------------------------------------------
   // Operand stack: top two entries in registers, the rest in memory.
   // The memory is read every cycle at the entry that will sit third from
   // the top, so a pop can refill the second register without waiting.
   // ---------------------------------------------------------------------
   logic [LV_W-1:0]   lv_ff, lv_in;
   logic [WORD_W-1:0] nos_ff, nos_in;
   logic [WORD_W-1:0] stk_mem [STACK_DEPTH];
   logic [WORD_W-1:0] stk_rd_ff;
   logic              stk_byp_ff;
   logic [WORD_W-1:0] stk_bypd_ff;
   logic              stk_we;
   logic [SA_W-1:0]   stk_wa;
   logic [SA_W-1:0]   stk_ra;
   logic [LV_W-1:0]   lv_m2;
   logic [LV_W-1:0]   lv_in_m3;
   logic [WORD_W-1:0] third;

   assign lv_m2    = lv_ff - LV_W'(2);
   assign lv_in_m3 = lv_in - LV_W'(3);
   assign stk_wa   = lv_m2[SA_W-1:0];
   assign stk_ra   = lv_in_m3[SA_W-1:0];
   assign third    = stk_byp_ff ? stk_bypd_ff : stk_rd_ff;

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_wa] <= nos_ff;
      end
      stk_rd_ff <= stk_mem[stk_ra];
   end

   always_ff @(posedge clock) begin
      stk_byp_ff  <= stk_we && (stk_wa == stk_ra);
      stk_bypd_ff <= nos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lv_ff <= '0;
      end else begin
         lv_ff <= lv_in;
      end
   end

   always_ff @(posedge clock) begin
      tos_ff <= tos_in;
      nos_ff <= nos_in;
   end

   // ---------------------------------------------------------------------
   // Execute
   // ---------------------------------------------------------------------
   sbe_rsp_type       res;
   logic              is_binary;
   logic [WORD_W-1:0] alu_r;
   logic [WORD_W-1:0] push_v;
   logic              push_ok;

   assign is_binary = (ex_req_ff.req_type <= OP_OR) && (ex_req_ff.req_type != OP_NOT);

   always_comb begin
      case (ex_req_ff.req_type)
         OP_ADD:  alu_r = nos_ff + tos_ff;
         OP_SUB:  alu_r = nos_ff - tos_ff;
         OP_EQ:   alu_r = (nos_ff == tos_ff) ? ALL_ONES : ALL_ZERO;
         OP_GT:   alu_r = ($signed(nos_ff) > $signed(tos_ff)) ? 32'd1 : 32'd0;
         OP_LT:   alu_r = ($signed(tos_ff) > $signed(nos_ff)) ? 32'd1 : 32'd0;
         OP_AND:  alu_r = nos_ff & tos_ff;
         default: alu_r = nos_ff | tos_ff;
      endcase
   end

   // Push source and its index check.
   always_comb begin
      push_v  = ALL_ZERO;
      push_ok = 1'b1;
      case (ex_req_ff.segment)
         SEG_CONST: push_v = ex_req_ff.operand;
         SEG_ARG: begin
            if (ex_req_ff.operand >= {29'd0, eff_args}) begin
               push_ok = 1'b0;
            end else begin
               push_v = arg_word_ff[ex_req_ff.operand[AI_W-1:0]];
            end
         end
         SEG_LOCAL: begin
            if (ex_req_ff.operand >= {23'd0, eff_locals}) begin
               push_ok = 1'b0;
            end else begin
               push_v = loc_val;
            end
         end
         default: push_v = ex_req_ff.host_value;
      endcase
   end

   always_comb begin
      res    = '0;
      lv_in  = lv_ff;
      tos_in = tos_ff;
      nos_in = nos_ff;
      stk_we = 1'b0;
      loc_we = 1'b0;
      if (exec_go) begin
         if (is_binary) begin
            if (lv_ff < LV_W'(2)) begin
               res.fault = FLT_UNDER;
            end else begin
               tos_in = alu_r;
               nos_in = third;
               lv_in  = lv_ff - LV_W'(1);
            end
         end else begin
            case (ex_req_ff.req_type)
               OP_NOT: begin
                  if (lv_ff == '0) begin
                     res.fault = FLT_UNDER;
                  end else begin
                     tos_in = ALL_ONES - tos_ff;
                  end
               end
               OP_CJUMP: begin
                  if (lv_ff == '0) begin
                     res.fault = FLT_UNDER;
                  end else begin
                     tos_in = nos_ff;
                     nos_in = third;
                     lv_in  = lv_ff - LV_W'(1);
                     if (tos_ff != ALL_ZERO) begin
                        res.jump_taken  = 1'b1;
                        res.jump_target = ex_req_ff.operand;
                     end
                  end
               end
               OP_JUMP: begin
                  res.jump_taken  = 1'b1;
                  res.jump_target = ex_req_ff.operand;
               end
               OP_STACK: begin
                  if (!ex_req_ff.is_pop) begin
                     // push: spill the second entry to memory
                     if (lv_ff >= LV_FULL) begin
                        res.fault = FLT_OVER;
                     end else if (!push_ok) begin
                        res.fault = FLT_INDEX;
                     end else begin
                        stk_we = (lv_ff >= LV_W'(2));
                        nos_in = tos_ff;
                        tos_in = push_v;
                        lv_in  = lv_ff + LV_W'(1);
                     end
                  end else if (lv_ff == '0) begin
                     res.fault = FLT_UNDER;
                  end else if ((ex_req_ff.segment == SEG_LOCAL) &&
                               (ex_req_ff.operand >= {23'd0, eff_locals})) begin
                     res.fault = FLT_INDEX;
                  end else begin
                     tos_in = nos_ff;
                     nos_in = third;
                     lv_in  = lv_ff - LV_W'(1);
                     loc_we = (ex_req_ff.segment == SEG_LOCAL);
                     if ((ex_req_ff.segment == SEG_HOST) && (ex_req_ff.operand <= FMT_MAX)) begin
                        res.out_valid  = 1'b1;
                        res.out_word   = tos_ff;
                        res.out_format = ex_req_ff.operand[1:0];
                     end
                  end
               end
               default: res = '0;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // Level never runs past the stack size.
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      lv_ff <= LV_FULL)
      else $error("stack level beyond depth");

   // Level moves only when an instruction executes.
   a_level_idle: assert property (@(posedge clock) disable iff (reset)
      !exec_go |=> $stable(lv_ff))
      else $error("stack level moved without execute");

   // One instruction moves the level by at most one.
   a_level_step: assert property (@(posedge clock) disable iff (reset)
      exec_go |=> (lv_ff == $past(lv_ff)) || (lv_ff == $past(lv_ff) + LV_W'(1)) ||
                  (lv_ff == $past(lv_ff) - LV_W'(1)))
      else $error("stack level jumped");

   // A faulting instruction leaves the level alone.
   a_fault_still: assert property (@(posedge clock) disable iff (reset)
      exec_go && (res.fault != FLT_NONE) |=> $stable(lv_ff))
      else $error("faulting instruction changed stack level");

   // An underflow is reported only on a short stack.
   a_under_cause: assert property (@(posedge clock) disable iff (reset)
      exec_go && (res.fault == FLT_UNDER) |-> lv_ff < LV_W'(2))
      else $error("underflow with a full enough stack");
`endif

endmodule

FILE: sim/sbe_exec_checker.sv
`timescale 1ns / 100ps
// Response checker for the stack bytecode executor: keeps its own copy of the machine state.
// It predicts each response word and compares it field by field. Depends on sbe_pkg.
module sbe_exec_checker #(
   parameter int STACK_DEPTH = sbe_pkg::DEF_STACK_DEPTH,
   parameter int LOCAL_DEPTH = sbe_pkg::DEF_LOCAL_DEPTH,
   parameter int ARG_SLOTS   = sbe_pkg::DEF_ARG_SLOTS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  sbe_pkg::sbe_req_type          req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  sbe_pkg::sbe_rsp_type          rsp_data,
   input  logic                          csr_wr_en,
   input  logic [sbe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sbe_pkg::WORD_W-1:0]    csr_wdata,
   output int                            error_count,
   output int                            pending_words
);
   import sbe_pkg::*;

   localparam int ARG_WORDS = 4;

   logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
   logic [WORD_W-1:0] local_mem [LOCAL_DEPTH];
   logic [WORD_W-1:0] arg_word_q [ARG_WORDS];
   logic [2:0]        arg_count_q;
   logic [8:0]        local_count_q;
   int unsigned       level;

   sbe_rsp_type       expected_rsp_q [$];
   sbe_rsp_type       oldest;
   int                errors = 0;

   // Apply one instruction to the shadow state and return the response it should give.
   function automatic sbe_rsp_type execute_instruction(input sbe_req_type w);
      sbe_rsp_type       r;
      logic [WORD_W-1:0] a, b, v, res;
      int unsigned       n_args, n_locals;
      r        = '0;
      v        = ALL_ZERO;
      res      = ALL_ZERO;
      n_args   = (arg_count_q > ARG_SLOTS) ? ARG_SLOTS : arg_count_q;
      n_locals = (local_count_q > LOCAL_DEPTH) ? LOCAL_DEPTH : local_count_q;
      case (w.req_type)
         OP_ADD, OP_SUB, OP_EQ, OP_GT, OP_LT, OP_AND, OP_OR: begin
            if (level < 2) begin
               r.fault = FLT_UNDER;
            end else begin
               b = stack_mem[level - 1];
               a = stack_mem[level - 2];
               case (w.req_type)
                  OP_ADD: res = a + b;
                  OP_SUB: res = a - b;
                  OP_EQ:  res = (a == b) ? ALL_ONES : ALL_ZERO;
                  OP_GT:  res = ($signed(a) > $signed(b)) ? 32'd1 : ALL_ZERO;
                  OP_LT:  res = ($signed(b) > $signed(a)) ? 32'd1 : ALL_ZERO;
                  OP_AND: res = a & b;
                  default: res = a | b;
               endcase
               stack_mem[level - 2] = res;
               level = level - 1;
            end
         end
         OP_NOT: begin
            if (level < 1) r.fault = FLT_UNDER;
            else stack_mem[level - 1] = ALL_ONES - stack_mem[level - 1];
         end
         OP_CJUMP: begin
            if (level < 1) begin
               r.fault = FLT_UNDER;
            end else begin
               v     = stack_mem[level - 1];
               level = level - 1;
               if (v != ALL_ZERO) begin
                  r.jump_taken  = 1'b1;
                  r.jump_target = w.operand;
               end
            end
         end
         OP_JUMP: begin
            r.jump_taken  = 1'b1;
            r.jump_target = w.operand;
         end
         OP_STACK: begin
            if (!w.is_pop) begin
               if (level >= STACK_DEPTH) begin
                  r.fault = FLT_OVER;
               end else begin
                  case (w.segment)
                     SEG_CONST: v = w.operand;
                     SEG_ARG: begin
                        if (w.operand >= n_args) r.fault = FLT_INDEX;
                        else v = arg_word_q[w.operand[1:0]];
                     end
                     SEG_LOCAL: begin
                        if (w.operand >= n_locals) r.fault = FLT_INDEX;
                        else v = local_mem[w.operand];
                     end
                     default: v = w.host_value;
                  endcase
                  if (r.fault == FLT_NONE) begin
                     stack_mem[level] = v;
                     level = level + 1;
                  end
               end
            end else if (level < 1) begin
               r.fault = FLT_UNDER;
            end else begin
               v = stack_mem[level - 1];
               if (w.segment == SEG_LOCAL) begin
                  if (w.operand >= n_locals) begin
                     r.fault = FLT_INDEX;
                  end else begin
                     local_mem[w.operand] = v;
                     level = level - 1;
                  end
               end else begin
                  // host segment on a pop means the output port; the rest discard
                  level = level - 1;
                  if (w.segment == SEG_HOST && w.operand <= FMT_MAX) begin
                     r.out_valid  = 1'b1;
                     r.out_word   = v;
                     r.out_format = w.operand[1:0];
                  end
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         level         = 0;
         arg_count_q   = '0;
         local_count_q = '0;
         foreach (arg_word_q[i]) arg_word_q[i] = ALL_ZERO;
         foreach (local_mem[i]) local_mem[i] = ALL_ZERO;
         expected_rsp_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ARG_COUNT:   arg_count_q   = csr_wdata[2:0];
               CSR_LOCAL_COUNT: local_count_q = csr_wdata[8:0];
               default: begin
                  if (csr_index >= CSR_ARG_WORD0 && csr_index - CSR_ARG_WORD0 < ARG_WORDS)
                     arg_word_q[csr_index - CSR_ARG_WORD0] = csr_wdata;
               end
            endcase
         end
         if (req_valid && !req_stall)
            expected_rsp_q = {expected_rsp_q, execute_instruction(req_data)};
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               $error("response word arrived with nothing expected");
               errors++;
            end else begin
               oldest = expected_rsp_q.pop_front();
               check_field("jump_taken",  oldest.jump_taken,  rsp_data.jump_taken);
               check_field("jump_target", oldest.jump_target, rsp_data.jump_target);
               check_field("out_valid",   oldest.out_valid,   rsp_data.out_valid);
               check_field("out_word",    oldest.out_word,    rsp_data.out_word);
               check_field("out_format",  oldest.out_format,  rsp_data.out_format);
               check_field("fault",       oldest.fault,       rsp_data.fault);
            end
         end
      end
      error_count   <= errors;
      pending_words <= expected_rsp_q.size();
   end

endmodule

FILE: sim/stack_bytecode_executor_unit_test.sv
`timescale 1ns / 100ps
// Top of the stack bytecode executor test: clock, reset, stimulus, stalls and the verdict.
// Depends on sbe_pkg, stack_bytecode_executor_unit and sbe_exec_checker.
module stack_bytecode_executor_unit_test;
   import sbe_pkg::*;

   localparam int          RANDOM_ITEMS   = 1300;
   localparam int          PHASES         = 8;
   localparam int          DRAIN_PAD      = 4;     // a margin past the request and response registers
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam logic [3:0]  OP_UNUSED_LO   = OP_STACK + 4'd1;
   localparam logic [3:0]  OP_UNUSED_HI   = 4'hF;
   localparam logic [31:0] INT_MIN_BITS   = 32'h8000_0000;
   localparam logic [31:0] INT_MAX_BITS   = 32'h7FFF_FFFF;

   typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_type;
   typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   sbe_req_type           req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   sbe_rsp_type           rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [WORD_W-1:0]     csr_wdata = '0;

   int                    error_count;
   int                    pending_words;

   // settings currently loaded, used to aim index operands near the limits
   int unsigned           cfg_arg_count   = 0;
   int unsigned           cfg_local_count = 0;

   int                    burst_left  = 0;
   stall_mode_type        stall_mode  = STALL_NONE;
   int                    stall_left  = 0;
   int                    stall_run   = 0;
   int                    idle_cycles = 0;

   always #5 clock = ~clock;

   stack_bytecode_executor_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sbe_exec_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_words (pending_words)
   );

   // Receiver back-pressure: switch at random between quiet, light, heavy and long-run
   // stall patterns so stalls land on every pipeline phase.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(40, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 4) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
         default: begin
            // hold the stall level for a run, then flip it
            if (stall_run == 0) begin
               rsp_stall <= ~rsp_stall;
               stall_run <= $urandom_range(1, 12);
            end else begin
               stall_run <= stall_run - 1;
            end
         end
      endcase
   end

   // Watchdog: end the run if neither channel moves a word for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   function automatic sbe_req_type mk(input logic [3:0] op, input logic pop,
                                      input logic [1:0] seg, input logic [31:0] operand,
                                      input logic [31:0] host);
      sbe_req_type w;
      w.req_type   = op;
      w.is_pop     = pop;
      w.segment    = seg;
      w.operand    = operand;
      w.host_value = host;
      return w;
   endfunction

   // Small values make equal operands likely; extremes hit the sign and wrap edges.
   function automatic logic [31:0] data_value();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 4) return $urandom_range(0, 3);
      if (r < 6) begin
         case ($urandom_range(0, 3))
            0: return ALL_ZERO;
            1: return ALL_ONES;
            2: return INT_MIN_BITS;
            default: return INT_MAX_BITS;
         endcase
      end
      return $urandom;
   endfunction

   // Mostly in range, some just past the limit, a few anywhere in 32 bits.
   function automatic logic [31:0] index_operand(input int unsigned count);
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r == 0) return $urandom;
      if (r < 4 || count == 0) return count + $urandom_range(0, 3);
      return $urandom_range(0, count - 1);
   endfunction

   function automatic sbe_req_type random_word(input mix_type mix);
      sbe_req_type w;
      int unsigned pick, push_pct, pop_pct, n_args, n_locals;
      n_args       = (cfg_arg_count > DEF_ARG_SLOTS) ? DEF_ARG_SLOTS : cfg_arg_count;
      n_locals     = (cfg_local_count > DEF_LOCAL_DEPTH) ? DEF_LOCAL_DEPTH : cfg_local_count;
      w.req_type   = OP_ADD;
      w.is_pop     = 1'($urandom);
      w.segment    = 2'($urandom);
      w.operand    = $urandom;
      w.host_value = data_value();
      case (mix)
         MIX_FILL:  begin push_pct = 65; pop_pct = 10; end
         MIX_DRAIN: begin push_pct = 20; pop_pct = 30; end
         default:   begin push_pct = 40; pop_pct = 20; end
      endcase
      pick = $urandom_range(0, 99);
      if (pick < push_pct) begin
         w.req_type = OP_STACK;
         w.is_pop   = 1'b0;
         case (w.segment)
            SEG_CONST: w.operand = data_value();
            SEG_ARG:   w.operand = index_operand(n_args);
            SEG_LOCAL: w.operand = index_operand(n_locals);
            default: ;   // host input ignores the operand
         endcase
      end else if (pick < push_pct + pop_pct) begin
         w.req_type = OP_STACK;
         w.is_pop   = 1'b1;
         if (w.segment == SEG_LOCAL)
            w.operand = index_operand(n_locals);
         else if (w.segment == SEG_HOST)
            w.operand = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 3)       w.req_type = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
         else if (pick < 8)  w.req_type = OP_JUMP;
         else if (pick < 18) w.req_type = OP_CJUMP;
         else if (pick < 26) w.req_type = OP_NOT;
         else begin
            case ($urandom_range(0, 6))
               0: w.req_type = OP_ADD;
               1: w.req_type = OP_SUB;
               2: w.req_type = OP_EQ;
               3: w.req_type = OP_GT;
               4: w.req_type = OP_LT;
               5: w.req_type = OP_AND;
               default: w.req_type = OP_OR;
            endcase
         end
      end
      return w;
   endfunction

   // Offer one word and hold it until accepted; then either keep valid up for the
   // rest of the burst or drop it for a random gap.
   task automatic send_word(input sbe_req_type w);
      int gap;
      req_data  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // Drop valid and wait until every expected response word has come back.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_words != 0);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   // Load one set of register values while the block is idle.
   task automatic load_settings(input int phase);
      logic [WORD_W-1:0] values [6];
      int                i;
      for (i = 0; i < DEF_ARG_SLOTS; i++) values[CSR_ARG_WORD0 + i] = $urandom;
      case (phase)
         0: begin
            values[CSR_ARG_COUNT]     = 4;
            values[CSR_LOCAL_COUNT]   = 256;
            values[CSR_ARG_WORD0]     = INT_MAX_BITS;
            values[CSR_ARG_WORD0 + 1] = INT_MIN_BITS;
            values[CSR_ARG_WORD0 + 2] = ALL_ZERO;
            values[CSR_ARG_WORD0 + 3] = ALL_ONES;
         end
         1: begin
            // counts above the slot limits clamp to the limits
            values[CSR_ARG_COUNT]   = 7;
            values[CSR_LOCAL_COUNT] = 511;
         end
         2: begin
            values[CSR_ARG_COUNT]   = 0;
            values[CSR_LOCAL_COUNT] = 0;
         end
         3: begin
            values[CSR_ARG_COUNT]   = 1;
            values[CSR_LOCAL_COUNT] = 1;
         end
         4: begin
            values[CSR_ARG_COUNT]   = 4;
            values[CSR_LOCAL_COUNT] = 8;
         end
         default: begin
            values[CSR_ARG_COUNT]   = $urandom_range(0, 7);
            values[CSR_LOCAL_COUNT] = $urandom_range(0, 1) ? $urandom_range(1, 16)
                                                           : $urandom_range(0, 511);
         end
      endcase
      wait_until_drained();
      for (i = 0; i < 6; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= CSR_ARG_COUNT + 3'(i);
         csr_wdata <= values[i];
         @(posedge clock);
      end
      csr_wr_en       <= 1'b0;
      cfg_arg_count   = values[CSR_ARG_COUNT][2:0];
      cfg_local_count = values[CSR_LOCAL_COUNT][8:0];
   endtask

   initial begin
      sbe_req_type directed_words [$];
      mix_type     mix;
      int          mix_left;
      int          phase, n;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed words at reset settings (no args, no locals):
      // underflow on every popping class, underflow ahead of a bad local index,
      // index faults, jump, unused class, then every operation but add on known values.
      directed_words = {directed_words, mk(OP_ADD,   0, SEG_CONST, ALL_ZERO, ALL_ZERO)};
      directed_words = {directed_words, mk(OP_NOT,   0, SEG_CONST, ALL_ZERO, ALL_ZERO)};
      directed_words = {directed_words, mk(OP_CJUMP, 0, SEG_CONST, ALL_ONES, ALL_ZERO)};
      directed_words = {directed_words, mk(OP_STACK, 1, SEG_LOCAL, ALL_ZERO, ALL_ZERO)};
      directed_words = {directed_words, mk(OP_STACK, 0, SEG_ARG,   ALL_ZERO, ALL_ZERO)};
      directed_words = {directed_words, mk(OP_STACK, 0, SEG_LOCAL, ALL_ZERO, ALL_ZERO)};
      directed_words = {directed_words, mk(OP_JUMP,  0, SEG_CONST, ALL_ONES, ALL_ZERO)};
      directed_words = {directed_words, mk(OP_UNUSED_HI, 1, SEG_HOST, ALL_ONES, ALL_ONES)};
      directed_words = {directed_words, mk(OP_STACK, 0, SEG_CONST, INT_MAX_BITS, ALL_ZERO)};
      directed_words = {directed_words, mk(OP_STACK, 0, SEG_CONST, INT_MIN_BITS, ALL_ZERO)};
      directed_words = {directed_words, mk(OP_GT,    0, SEG_CONST, ALL_ZERO, ALL_ZERO)};
      // host input pushes host_value; the operand is ignored
      directed_words = {directed_words, mk(OP_STACK, 0, SEG_HOST,  ALL_ONES, INT_MIN_BITS)};
      directed_words = {directed_words, mk(OP_LT,    0, SEG_CONST, ALL_ZERO, ALL_ZERO)};
      directed_words = {directed_words, mk(OP_NOT,   0, SEG_CONST, ALL_ZERO, ALL_ZERO)};
      directed_words = {directed_words, mk(OP_STACK, 0, SEG_CONST, ALL_ONES, ALL_ZERO)};
      directed_words = {directed_words, mk(OP_EQ,    0, SEG_CONST, ALL_ZERO, ALL_ZERO)};
      directed_words = {directed_words, mk(OP_STACK, 0, SEG_CONST, 32'h0F0F_0F0F, ALL_ZERO)};
      directed_words = {directed_words, mk(OP_AND,   0, SEG_CONST, ALL_ZERO, ALL_ZERO)};
      directed_words = {directed_words, mk(OP_STACK, 0, SEG_CONST, 32'hF0F0_F0F0, ALL_ZERO)};
      directed_words = {directed_words, mk(OP_OR,    0, SEG_CONST, ALL_ZERO, ALL_ZERO)};
      directed_words = {directed_words, mk(OP_STACK, 0, SEG_CONST, 32'd1, ALL_ZERO)};
      directed_words = {directed_words, mk(OP_SUB,   0, SEG_CONST, ALL_ZERO, ALL_ZERO)};
      // character output carries the whole word
      directed_words = {directed_words, mk(OP_STACK, 1, SEG_HOST,  32'd1, ALL_ZERO)};
      directed_words = {directed_words, mk(OP_STACK, 0, SEG_CONST, ALL_ZERO, ALL_ZERO)};
      directed_words = {directed_words, mk(OP_CJUMP, 0, SEG_CONST, 32'hA5A5_A5A5, ALL_ZERO)};
      directed_words = {directed_words, mk(OP_STACK, 0, SEG_CONST, 32'd3, ALL_ZERO)};
      directed_words = {directed_words, mk(OP_CJUMP, 0, SEG_CONST, 32'h5A5A_5A5A, ALL_ZERO)};
      foreach (directed_words[i]) send_word(directed_words[i]);

      // Random phases: fill, drain and even mixes walk the stack through
      // underflow, mid-range and overflow under each register setting.
      mix_left = 0;
      mix      = MIX_EVEN;
      for (phase = 0; phase < PHASES; phase++) begin
         load_settings(phase);
         for (n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
            if (mix_left == 0) begin
               mix      = mix_type'($urandom_range(0, 2));
               mix_left = $urandom_range(15, 60);
            end
            mix_left--;
            send_word(random_word(mix));
         end
      end

      wait_until_drained();
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/sbe_pkg.sv
hdl/stack_bytecode_executor_unit.sv
sim/sbe_exec_checker.sv
sim/stack_bytecode_executor_unit_test.sv
